/* design/swk_pkg.sv */
// shared constants, register codes and helper functions for the swerve wheel kinematics block
// no dependencies; imported by every module of the block
package swk_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_HALF_X  = 3'd0;
    localparam logic [2:0] REG_HALF_Y  = 3'd1;
    localparam logic [2:0] REG_RADIUS  = 3'd2;
    localparam logic [2:0] REG_LIMIT   = 3'd3;
    localparam logic [2:0] REG_DBAND   = 3'd4;

    localparam logic [14:0] RST_HALF_X = 15'd819;
    localparam logic [14:0] RST_HALF_Y = 15'd819;
    localparam logic [14:0] RST_RADIUS = 15'd205;
    localparam logic [14:0] RST_LIMIT  = 15'd2560;
    localparam logic [7:0]  RST_DBAND  = 8'd4;

    localparam logic [1:0] KIND_STOP  = 2'd0;
    localparam logic [1:0] KIND_TRANS = 2'd1;
    localparam logic [1:0] KIND_ROT   = 2'd2;
    localparam logic [1:0] KIND_SWIV  = 2'd3;

    localparam logic [15:0] HALF_TURN    = 16'h8000;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    typedef logic signed [15:0] angle_t;

    // arctangent of 2^-i in binary angle units
    function automatic logic [15:0] swk_atan_step(input logic [3:0] i);
        logic [15:0] r;
        case (i)
            4'd0:    r = 16'd8192;
            4'd1:    r = 16'd4836;
            4'd2:    r = 16'd2555;
            4'd3:    r = 16'd1297;
            4'd4:    r = 16'd651;
            4'd5:    r = 16'd326;
            4'd6:    r = 16'd163;
            4'd7:    r = 16'd81;
            4'd8:    r = 16'd41;
            4'd9:    r = 16'd20;
            4'd10:   r = 16'd10;
            4'd11:   r = 16'd5;
            4'd12:   r = 16'd3;
            4'd13:   r = 16'd1;
            4'd14:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // true when the goal turned by half a turn lies closer to the measured angle
    function automatic logic swk_flip(input angle_t g, input angle_t m);
        logic signed [16:0] alt;
        logic signed [16:0] da;
        logic signed [16:0] dg;
        logic [16:0] ma;
        logic [16:0] mg;
        alt = 17'(signed'(g ^ HALF_TURN));
        da  = alt - 17'(m);
        dg  = 17'(g) - 17'(m);
        ma  = da[16] ? 17'(-da) : 17'(da);
        mg  = dg[16] ? 17'(-dg) : 17'(dg);
        return (ma < mg) && (ma < 17'd32768);
    endfunction

endpackage

/* design/swk_isqrt.sv */
// iterative integer square root, one result bit per cycle
// depends on swk_pkg
module swk_isqrt
    import swk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] val,
    output logic        busy,
    output logic [31:0] root
);

    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [63:0] src_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [35:0] rem_t;
    logic [35:0] trial;

    assign rem_t    = {rem_reg, src_reg[63:62]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign busy     = (cnt_reg != 6'd0);
    assign root     = root_reg;
    assign cnt_next = start ? 6'd32 : (busy ? cnt_reg - 6'd1 : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            src_reg  <= val;
            rem_reg  <= 34'd0;
            root_reg <= 32'd0;
        end
        else if (busy)
        begin
            src_reg <= {src_reg[61:0], 2'b00};
            if (rem_t >= trial)
            begin
                rem_reg  <= 34'(rem_t - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_t[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

endmodule

/* design/swk_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// depends on swk_pkg
module swk_div
    import swk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [26:0] divisor,
    output logic        busy,
    output logic [39:0] quotient
);

    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [39:0] dvd_reg;
    logic [26:0] dsr_reg;
    logic [26:0] rem_reg;
    logic [27:0] rem_t;
    logic        fits;

    assign rem_t    = {rem_reg, dvd_reg[39]};
    assign fits     = (rem_t >= {1'b0, dsr_reg});
    assign busy     = (cnt_reg != 6'd0);
    assign quotient = dvd_reg;
    assign cnt_next = start ? 6'd40 : (busy ? cnt_reg - 6'd1 : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= 27'd0;
        end
        else if (busy)
        begin
            dvd_reg <= {dvd_reg[38:0], fits};
            rem_reg <= fits ? 27'(rem_t - {1'b0, dsr_reg}) : rem_t[26:0];
        end
    end

endmodule

/* design/swk_cordic.sv */
// iterative vectoring cordic giving a binary-angle atan2
// depends on swk_pkg for the arctangent steps
module swk_cordic
    import swk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] y_in,
    input  logic signed [32:0] x_in,
    output logic               busy,
    output angle_t             angle
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_ROT  = 2'd2;
    localparam logic signed [35:0] NORM_LIM = 36'sd536870912;

    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic [15:0]        acc_reg;
    logic [3:0]         it_reg;
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic               x_small;
    logic               y_small;
    logic               zero_in;

    assign xs      = x_reg >>> it_reg;
    assign ys      = y_reg >>> it_reg;
    assign x_small = (x_reg < NORM_LIM) && (x_reg > -NORM_LIM);
    assign y_small = (y_reg < NORM_LIM) && (y_reg > -NORM_LIM);
    assign zero_in = (x_in == 33'sd0) && (y_in == 33'sd0);
    assign busy    = (phase_reg != PH_IDLE);
    assign angle   = angle_t'(acc_reg);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start && !zero_in)
                begin
                    phase_next = PH_NORM;
                end
            end
            PH_NORM:
            begin
                if (!(x_small && y_small))
                begin
                    phase_next = PH_ROT;
                end
            end
            PH_ROT:
            begin
                if ((y_reg == 36'sd0) || (it_reg == 4'd14))
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    it_reg <= 4'd0;
                    if (x_in < 33'sd0)
                    begin
                        x_reg   <= -36'(x_in);
                        y_reg   <= -36'(y_in);
                        acc_reg <= HALF_TURN;
                    end
                    else
                    begin
                        x_reg   <= 36'(x_in);
                        y_reg   <= 36'(y_in);
                        acc_reg <= 16'd0;
                    end
                end
            end
            PH_NORM:
            begin
                if (x_small && y_small)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            PH_ROT:
            begin
                if (y_reg != 36'sd0)
                begin
                    it_reg <= it_reg + 4'd1;
                    if (y_reg > 36'sd0)
                    begin
                        x_reg   <= x_reg + ys;
                        y_reg   <= y_reg - xs;
                        acc_reg <= acc_reg + swk_atan_step(it_reg);
                    end
                    else
                    begin
                        x_reg   <= x_reg - ys;
                        y_reg   <= y_reg + xs;
                        acc_reg <= acc_reg - swk_atan_step(it_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* design/swerve_wheel_kinematics_top.sv */
// Four-wheel swerve inverse kinematics. One body twist and four measured steer angles per
// transfer give a motion kind plus steer goal and drive speed per wheel. The block works
// on one item at a time and drops in_ready until the result is loaded into the output
// register. Stop items skip the per-wheel work; for the other kinds the time taken is set
// by the shared 32-step square root, the 40-step divider and the cordic normalise and
// rotate loop (up to 44 steps per wheel), all driven by one sequencer around a single
// registered 33x33 multiplier.
// depends on swk_pkg, swk_isqrt, swk_div and swk_cordic
module swerve_wheel_kinematics_top
    import swk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  linear_x,
    input  logic signed [15:0]  linear_y,
    input  logic signed [15:0]  angular_z,
    input  logic signed [15:0]  measured_angle_fl,
    input  logic signed [15:0]  measured_angle_fr,
    input  logic signed [15:0]  measured_angle_bl,
    input  logic signed [15:0]  measured_angle_br,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          motion_kind,
    output logic signed [15:0]  steer_fl,
    output logic signed [15:0]  steer_fr,
    output logic signed [15:0]  steer_bl,
    output logic signed [15:0]  steer_br,
    output logic signed [15:0]  speed_fl,
    output logic signed [15:0]  speed_fr,
    output logic signed [15:0]  speed_bl,
    output logic signed [15:0]  speed_br
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_P0     = 5'd1;
    localparam logic [4:0] ST_P1     = 5'd2;
    localparam logic [4:0] ST_P2     = 5'd3;
    localparam logic [4:0] ST_P3     = 5'd4;
    localparam logic [4:0] ST_P4     = 5'd5;
    localparam logic [4:0] ST_P5     = 5'd6;
    localparam logic [4:0] ST_P6     = 5'd7;
    localparam logic [4:0] ST_WSET   = 5'd8;
    localparam logic [4:0] ST_SW0    = 5'd9;
    localparam logic [4:0] ST_SW1    = 5'd10;
    localparam logic [4:0] ST_SW2    = 5'd11;
    localparam logic [4:0] ST_SW3    = 5'd12;
    localparam logic [4:0] ST_SW4    = 5'd13;
    localparam logic [4:0] ST_SQ_GO  = 5'd14;
    localparam logic [4:0] ST_SQ_WT  = 5'd15;
    localparam logic [4:0] ST_RMUL   = 5'd16;
    localparam logic [4:0] ST_DV_GO  = 5'd17;
    localparam logic [4:0] ST_DV_WT  = 5'd18;
    localparam logic [4:0] ST_AT_GO  = 5'd19;
    localparam logic [4:0] ST_AT_WT  = 5'd20;
    localparam logic [4:0] ST_STORE  = 5'd21;
    localparam logic [4:0] ST_OUT    = 5'd22;

    // configuration
    logic [14:0] hx_reg;
    logic [14:0] hy_reg;
    logic [14:0] rad_reg;
    logic [14:0] lim_reg;
    logic [7:0]  db_reg;
    logic [14:0] rad_eff;
    logic        cfg_wr;

    // control
    logic [4:0]  state_reg;
    logic [4:0]  state_next;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_new;
    logic [1:0]  wheel_reg;
    logic        out_valid_reg;
    angle_t      last_reg [4];

    // datapath
    logic signed [15:0] vx_reg;
    logic signed [15:0] vy_reg;
    logic signed [15:0] wz_reg;
    angle_t             meas_reg [4];
    logic [31:0]        v2_reg;
    logic [31:0]        d2_reg;
    logic signed [32:0] y_reg;
    logic signed [32:0] x_reg;
    logic [63:0]        s2_reg;
    logic signed [15:0] spd_reg;
    logic signed [15:0] spdw_reg [4];
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;

    logic [1:0]         kind_out_reg;
    angle_t             steer_out_reg [4];
    logic signed [15:0] speed_out_reg [4];

    // derived operands
    logic signed [32:0] vx33;
    logic signed [32:0] vy33;
    logic signed [32:0] wz33;
    logic signed [32:0] aw33;
    logic signed [32:0] px33;
    logic signed [32:0] py33;
    logic signed [32:0] ap33;
    logic signed [32:0] aq33;
    logic [16:0]        ax17;
    logic [16:0]        ay17;
    logic               lin;
    logic               wz_nz;
    logic               swivel_big;
    logic               accept_in;
    logic               load_out;

    // shared units
    logic        sq_start;
    logic        sq_busy;
    logic [63:0] sq_in;
    logic [31:0] sq_root;
    logic        dv_start;
    logic        dv_busy;
    logic [39:0] dv_dividend;
    logic [26:0] dv_divisor;
    logic [39:0] dv_quo;
    logic        at_start;
    logic        at_busy;
    angle_t      at_angle;

    logic [14:0]        clamp_val;
    logic signed [15:0] spd_calc;
    angle_t             goal;
    logic               do_flip;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign rad_eff   = (rad_reg == 15'd0) ? 15'd1 : rad_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept_in = in_valid && in_ready;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        unique case (paddr[4:2])
            REG_HALF_X: prdata = {17'd0, hx_reg};
            REG_HALF_Y: prdata = {17'd0, hy_reg};
            REG_RADIUS: prdata = {17'd0, rad_reg};
            REG_LIMIT:  prdata = {17'd0, lim_reg};
            REG_DBAND:  prdata = {24'd0, db_reg};
            default:    prdata = '0;
        endcase
    end

    assign vx33 = 33'(vx_reg);
    assign vy33 = 33'(vy_reg);
    assign wz33 = 33'(wz_reg);
    assign aw33 = wz_reg[15] ? -wz33 : wz33;
    assign px33 = wheel_reg[1] ? -33'sd0 - 33'($signed({1'b0, hx_reg})) :
                                 33'($signed({1'b0, hx_reg}));
    assign py33 = wheel_reg[0] ? -33'sd0 - 33'($signed({1'b0, hy_reg})) :
                                 33'($signed({1'b0, hy_reg}));
    assign ap33 = y_reg[32] ? -y_reg : y_reg;
    assign aq33 = x_reg[32] ? -x_reg : x_reg;
    assign ax17 = vx_reg[15] ? 17'(-17'(vx_reg)) : 17'(vx_reg);
    assign ay17 = vy_reg[15] ? 17'(-17'(vy_reg)) : 17'(vy_reg);
    assign lin   = (vx_reg != 16'sd0) || (vy_reg != 16'sd0);
    assign wz_nz = (wz_reg != 16'sd0);
    assign swivel_big = ({6'd0, v2_reg, 24'd0} > 62'(prod_reg[61:0]));

    always_comb
    begin
        if (lin && !wz_nz)
        begin
            kind_new = KIND_TRANS;
        end
        else if ((ax17 <= {9'd0, db_reg}) && (ay17 <= {9'd0, db_reg}) && wz_nz)
        begin
            kind_new = KIND_ROT;
        end
        else if (lin && wz_nz)
        begin
            kind_new = swivel_big ? KIND_SWIV : KIND_ROT;
        end
        else
        begin
            kind_new = KIND_STOP;
        end
    end

    // shared multiplier operand selection
    assign mul_en = state_reg inside {ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
                                      ST_SW0, ST_SW1, ST_SW2, ST_SW3, ST_RMUL};

    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (state_reg)
            ST_P0:
            begin
                mul_a = vx33;
                mul_b = vx33;
            end
            ST_P1:
            begin
                mul_a = vy33;
                mul_b = vy33;
            end
            ST_P2:
            begin
                mul_a = 33'($signed({1'b0, hx_reg}));
                mul_b = 33'($signed({1'b0, hx_reg}));
            end
            ST_P3:
            begin
                mul_a = 33'($signed({1'b0, hy_reg}));
                mul_b = 33'($signed({1'b0, hy_reg}));
            end
            ST_P4:
            begin
                mul_a = wz33;
                mul_b = wz33;
            end
            ST_P5:
            begin
                mul_a = $signed({1'b0, d2_reg});
                mul_b = prod_reg[32:0];
            end
            ST_SW0:
            begin
                mul_a = py33;
                mul_b = wz33;
            end
            ST_SW1:
            begin
                mul_a = px33;
                mul_b = wz33;
            end
            ST_SW2:
            begin
                mul_a = ap33;
                mul_b = ap33;
            end
            ST_SW3:
            begin
                mul_a = aq33;
                mul_b = aq33;
            end
            ST_RMUL:
            begin
                mul_a = aw33;
                mul_b = $signed({1'b0, sq_root});
            end
            default:
            begin
            end
        endcase
    end

    // unit operands
    always_comb
    begin
        case (kind_reg)
            KIND_TRANS:
            begin
                sq_in      = {16'd0, v2_reg, 16'd0};
                dv_divisor = {12'd0, rad_eff};
                dv_dividend = {8'd0, sq_root};
            end
            KIND_ROT:
            begin
                sq_in      = {16'd0, d2_reg, 16'd0};
                dv_divisor = {rad_eff, 12'd0};
                dv_dividend = prod_reg[39:0];
            end
            default:
            begin
                sq_in      = s2_reg;
                dv_divisor = {8'd0, rad_eff, 4'd0};
                dv_dividend = {8'd0, sq_root};
            end
        endcase
    end

    assign sq_start = (state_reg == ST_SQ_GO);
    assign dv_start = (state_reg == ST_DV_GO);
    assign at_start = (state_reg == ST_AT_GO);

    always_comb
    begin
        if (kind_reg == KIND_SWIV)
        begin
            clamp_val = (dv_quo > 40'd32767) ? 15'h7FFF : dv_quo[14:0];
        end
        else
        begin
            clamp_val = (dv_quo > {25'd0, lim_reg}) ? lim_reg : dv_quo[14:0];
        end
        if ((kind_reg == KIND_ROT) && wz_reg[15])
        begin
            spd_calc = -$signed({1'b0, clamp_val});
        end
        else
        begin
            spd_calc = $signed({1'b0, clamp_val});
        end
    end

    assign goal    = (kind_reg == KIND_TRANS) ? at_angle : angle_t'(at_angle + QUARTER_TURN);
    assign do_flip = swk_flip(goal, meas_reg[wheel_reg]);

    swk_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   (sq_in),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    swk_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_dividend),
        .divisor  (dv_divisor),
        .busy     (dv_busy),
        .quotient (dv_quo)
    );

    swk_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (at_start),
        .y_in  (y_reg),
        .x_in  (x_reg),
        .busy  (at_busy),
        .angle (at_angle)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = accept_in ? ST_P0 : ST_IDLE;
            ST_P0:    state_next = ST_P1;
            ST_P1:    state_next = ST_P2;
            ST_P2:    state_next = ST_P3;
            ST_P3:    state_next = ST_P4;
            ST_P4:    state_next = ST_P5;
            ST_P5:    state_next = ST_P6;
            ST_P6:    state_next = (kind_new == KIND_STOP) ? ST_OUT : ST_WSET;
            ST_WSET:
            begin
                if (kind_reg == KIND_SWIV)
                begin
                    state_next = ST_SW0;
                end
                else if (wheel_reg == 2'd0)
                begin
                    state_next = ST_SQ_GO;
                end
                else
                begin
                    state_next = ST_AT_GO;
                end
            end
            ST_SW0:   state_next = ST_SW1;
            ST_SW1:   state_next = ST_SW2;
            ST_SW2:   state_next = ST_SW3;
            ST_SW3:   state_next = ST_SW4;
            ST_SW4:   state_next = ST_SQ_GO;
            ST_SQ_GO: state_next = ST_SQ_WT;
            ST_SQ_WT:
            begin
                if (!sq_busy)
                begin
                    state_next = (kind_reg == KIND_ROT) ? ST_RMUL : ST_DV_GO;
                end
            end
            ST_RMUL:  state_next = ST_DV_GO;
            ST_DV_GO: state_next = ST_DV_WT;
            ST_DV_WT: state_next = dv_busy ? ST_DV_WT : ST_AT_GO;
            ST_AT_GO: state_next = ST_AT_WT;
            ST_AT_WT: state_next = at_busy ? ST_AT_WT : ST_STORE;
            ST_STORE: state_next = (wheel_reg == 2'd3) ? ST_OUT : ST_WSET;
            ST_OUT:   state_next = load_out ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_STOP;
            wheel_reg     <= 2'd0;
            hx_reg        <= RST_HALF_X;
            hy_reg        <= RST_HALF_Y;
            rad_reg       <= RST_RADIUS;
            lim_reg       <= RST_LIMIT;
            db_reg        <= RST_DBAND;
            for (int i = 0; i < 4; i++)
            begin
                last_reg[i] <= 16'sd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    REG_HALF_X: hx_reg  <= pwdata[14:0];
                    REG_HALF_Y: hy_reg  <= pwdata[14:0];
                    REG_RADIUS: rad_reg <= pwdata[14:0];
                    REG_LIMIT:  lim_reg <= pwdata[14:0];
                    REG_DBAND:  db_reg  <= pwdata[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_P6)
            begin
                kind_reg  <= kind_new;
                wheel_reg <= 2'd0;
            end
            if (state_reg == ST_STORE)
            begin
                last_reg[wheel_reg] <= do_flip ? angle_t'(goal ^ HALF_TURN) : goal;
                wheel_reg <= wheel_reg + 2'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (accept_in)
        begin
            vx_reg      <= linear_x;
            vy_reg      <= linear_y;
            wz_reg      <= angular_z;
            meas_reg[0] <= measured_angle_fl;
            meas_reg[1] <= measured_angle_fr;
            meas_reg[2] <= measured_angle_bl;
            meas_reg[3] <= measured_angle_br;
        end
        case (state_reg)
            ST_P1: v2_reg <= prod_reg[31:0];
            ST_P2: v2_reg <= v2_reg + prod_reg[31:0];
            ST_P3: d2_reg <= prod_reg[31:0];
            ST_P4: d2_reg <= d2_reg + prod_reg[31:0];
            ST_P6:
            begin
                if (kind_new == KIND_STOP)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        spdw_reg[i] <= 16'sd0;
                    end
                end
            end
            ST_WSET:
            begin
                if (kind_reg == KIND_TRANS)
                begin
                    y_reg <= vy33;
                    x_reg <= vx33;
                end
                else if (kind_reg == KIND_ROT)
                begin
                    y_reg <= py33;
                    x_reg <= px33;
                end
            end
            ST_SW1: y_reg  <= prod_reg[32:0] - (vx33 <<< 12);
            ST_SW2: x_reg  <= prod_reg[32:0] + (vy33 <<< 12);
            ST_SW3: s2_reg <= prod_reg[63:0];
            ST_SW4: s2_reg <= s2_reg + prod_reg[63:0];
            ST_DV_WT:
            begin
                if (!dv_busy)
                begin
                    spd_reg <= spd_calc;
                end
            end
            ST_STORE: spdw_reg[wheel_reg] <= do_flip ? -spd_reg : spd_reg;
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            kind_out_reg <= kind_reg;
            for (int i = 0; i < 4; i++)
            begin
                steer_out_reg[i] <= last_reg[i];
                speed_out_reg[i] <= spdw_reg[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign motion_kind = kind_out_reg;
    assign steer_fl    = steer_out_reg[0];
    assign steer_fr    = steer_out_reg[1];
    assign steer_bl    = steer_out_reg[2];
    assign steer_br    = steer_out_reg[3];
    assign speed_fl    = speed_out_reg[0];
    assign speed_fr    = speed_out_reg[1];
    assign speed_bl    = speed_out_reg[2];
    assign speed_br    = speed_out_reg[3];

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_stop_speeds_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (motion_kind == KIND_STOP)) |->
        (speed_fl == 16'sd0 && speed_fr == 16'sd0 && speed_bl == 16'sd0 && speed_br == 16'sd0))
        else $error("stop result with a nonzero speed");

    a_result_from_sequencer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result shown without finishing an item");
`endif

endmodule

/* tb/testbench.sv */
// self-checking testbench for swerve_wheel_kinematics_top: apb register setup, random twist stream
// bit-exact integer predictor of motion kind, steer goals and wheel speeds; depends on swk_pkg
module testbench;
    import swk_pkg::*;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] wz;
        logic signed [15:0] m0;
        logic signed [15:0] m1;
        logic signed [15:0] m2;
        logic signed [15:0] m3;
    } twist_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] s0;
        logic signed [15:0] s1;
        logic signed [15:0] s2;
        logic signed [15:0] s3;
        logic signed [15:0] v0;
        logic signed [15:0] v1;
        logic signed [15:0] v2;
        logic signed [15:0] v3;
    } wheel_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] linear_x = '0, linear_y = '0, angular_z = '0;
    logic signed [15:0] measured_angle_fl = '0, measured_angle_fr = '0;
    logic signed [15:0] measured_angle_bl = '0, measured_angle_br = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] motion_kind;
    logic signed [15:0] steer_fl, steer_fr, steer_bl, steer_br;
    logic signed [15:0] speed_fl, speed_fr, speed_bl, speed_br;

    swerve_wheel_kinematics_top u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    longint half_x, half_y, radius, speed_lim, dband;
    int prev_goal [4];

    twist_t     twist_q [$];
    wheel_cmd_t cmd_q [$];
    int  mismatches = 0;
    int  accepted = 0;
    int  busy_sends = 0;
    bit  calm = 1'b0;
    bit  hold_send = 1'b0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint fshift(longint v, int s);
        return v >= 0 ? (v >>> s) : (-((-(v + 1)) >>> s) - 1);
    endfunction

    function automatic longint root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int wrap_angle(longint v);
        logic signed [15:0] w;
        w = v[15:0];
        return w;
    endfunction

    function automatic int heading(longint y, longint x);
        int acc, steps [15];
        longint nx, ny;
        steps = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = 32768;
        end
        while (mag(x) < 64'd536870912 && mag(y) < 64'd536870912)
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 15; i++)
        begin
            if (y == 0) break;
            if (y > 0)
            begin
                nx = x + fshift(y, i);
                ny = y - fshift(x, i);
                acc += steps[i];
            end
            else
            begin
                nx = x - fshift(y, i);
                ny = y + fshift(x, i);
                acc -= steps[i];
            end
            x = nx;
            y = ny;
        end
        return wrap_angle(acc);
    endfunction

    function automatic wheel_cmd_t predict_wheels(twist_t t);
        wheel_cmd_t c;
        longint vx, vy, wz, rad, d2, v2, s, p, q;
        longint px [4], py [4];
        int g [4], spd [4], ms [4], alt, da, dg, a;
        logic [1:0] kind;
        bit lin;
        vx = t.vx; vy = t.vy; wz = t.wz;
        ms = '{t.m0, t.m1, t.m2, t.m3};
        rad = radius != 0 ? radius : 1;
        px = '{half_x, half_x, -half_x, -half_x};
        py = '{half_y, -half_y, half_y, -half_y};
        d2 = half_x * half_x + half_y * half_y;
        v2 = vx * vx + vy * vy;
        lin = (vx != 0) || (vy != 0);
        if (lin && wz == 0)
            kind = KIND_TRANS;
        else if (mag(vx) <= dband && mag(vy) <= dband && wz != 0)
            kind = KIND_ROT;
        else if (lin && wz != 0)
            kind = ((longint'(v2) << 24) > d2 * (wz * wz)) ? KIND_SWIV : KIND_ROT;
        else
            kind = KIND_STOP;
        if (kind == KIND_STOP)
        begin
            g = prev_goal;
            spd = '{0, 0, 0, 0};
        end
        else
        begin
            if (kind == KIND_TRANS)
            begin
                a = heading(vy, vx);
                s = root(v2 << 16) / rad;
                if (s > speed_lim) s = speed_lim;
                for (int i = 0; i < 4; i++)
                begin
                    g[i] = a;
                    spd[i] = int'(s);
                end
            end
            else if (kind == KIND_ROT)
            begin
                s = (mag(wz) * root(d2 << 16)) / (rad * 4096);
                if (s > speed_lim) s = speed_lim;
                if (wz < 0) s = -s;
                for (int i = 0; i < 4; i++)
                begin
                    g[i] = wrap_angle(heading(py[i], px[i]) + 16384);
                    spd[i] = int'(s);
                end
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    p = py[i] * wz - vx * 4096;
                    q = px[i] * wz + vy * 4096;
                    s = root(mag(p) * mag(p) + mag(q) * mag(q)) / (rad * 16);
                    if (s > 32767) s = 32767;
                    g[i] = wrap_angle(heading(p, q) + 16384);
                    spd[i] = int'(s);
                end
            end
            for (int i = 0; i < 4; i++)
            begin
                alt = g[i] >= 0 ? g[i] - 32768 : g[i] + 32768;
                da = alt - ms[i];
                dg = g[i] - ms[i];
                if (da < 0) da = -da;
                if (dg < 0) dg = -dg;
                if (da < dg && da < 32768)
                begin
                    g[i] = alt;
                    spd[i] = -spd[i];
                end
                prev_goal[i] = g[i];
            end
        end
        c.kind = kind;
        c.s0 = 16'(g[0]); c.s1 = 16'(g[1]); c.s2 = 16'(g[2]); c.s3 = 16'(g[3]);
        c.v0 = 16'(spd[0]); c.v1 = 16'(spd[1]); c.v2 = 16'(spd[2]); c.v3 = 16'(spd[3]);
        return c;
    endfunction

    // driver
    bit accepted_now;
    always @(posedge clk) accepted_now <= in_valid && in_ready;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
            if (in_valid && !accepted_now)
            begin
            end
            else if (twist_q.size() != 0 && !hold_send && (calm || $urandom_range(99) >= 14))
            begin
                in_valid          <= 1'b1;
                linear_x          <= twist_q[0].vx;
                linear_y          <= twist_q[0].vy;
                angular_z         <= twist_q[0].wz;
                measured_angle_fl <= twist_q[0].m0;
                measured_angle_fr <= twist_q[0].m1;
                measured_angle_bl <= twist_q[0].m2;
                measured_angle_br <= twist_q[0].m3;
                void'(twist_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // prediction on transfer and output monitor
    always @(posedge clk)
    begin
        twist_t t;
        wheel_cmd_t e, got;
        if (in_valid && in_ready)
        begin
            t = '{linear_x, linear_y, angular_z, measured_angle_fl, measured_angle_fr,
                  measured_angle_bl, measured_angle_br};
            cmd_q.push_back(predict_wheels(t));
            accepted++;
        end
        if (out_valid && out_ready)
        begin
            got = '{motion_kind, steer_fl, steer_fr, steer_bl, steer_br,
                    speed_fl, speed_fr, speed_bl, speed_br};
            if (cmd_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                e = cmd_q.pop_front();
                if (got !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", e, got);
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input longint val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(idx) << 2; pwdata <= DATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_HALF_X: half_x = val;
            REG_HALF_Y: half_y = val;
            REG_RADIUS: radius = val;
            REG_LIMIT:  speed_lim = val;
            default:    dband = val;
        endcase
    endtask

    task automatic drain();
        while (twist_q.size() != 0 || in_valid || cmd_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_geometry(longint hx, longint hy, longint r, longint l, longint d);
        apb_write(REG_HALF_X, hx);
        apb_write(REG_HALF_Y, hy);
        apb_write(REG_RADIUS, r);
        apb_write(REG_LIMIT, l);
        apb_write(REG_DBAND, d);
    endtask

    function automatic logic signed [15:0] rnd_field();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(16)) - 8);
            3: return 16'($signed($urandom_range(600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_twist(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic signed [15:0] wz);
        twist_q.push_back('{vx, vy, wz, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom)});
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: add_twist(0, 0, 0);
                1: add_twist(rnd_field(), rnd_field(), 0);
                2: add_twist(16'($signed($urandom_range(8)) - 4),
                             16'($signed($urandom_range(8)) - 4), rnd_field());
                default: add_twist(rnd_field(), rnd_field(), rnd_field());
            endcase
        end
    endtask

    initial
    begin
        half_x = RST_HALF_X; half_y = RST_HALF_Y; radius = RST_RADIUS;
        speed_lim = RST_LIMIT; dband = RST_DBAND;
        prev_goal = '{0, 0, 0, 0};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed: defaults
        add_twist(0, 0, 0);
        add_twist(16'sh7fff, 0, 0);
        add_twist(16'sh8000, 0, 0);
        add_twist(-100, 0, 0);
        add_twist(0, 16'sh8000, 0);
        add_twist(0, 0, 16'sh7fff);
        add_twist(0, 0, 16'sh8000);
        add_twist(3, -4, 100);
        add_twist(16'sh7fff, 16'sh8000, 1);
        add_twist(16'sh8000, 16'sh8000, 16'sh8000);
        add_twist(200, 50, 10);
        add_twist(0, 0, 0);
        twist_q.push_back('{16'sd100, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd1});
        drain();
        // zero spacing, zero radius
        set_geometry(0, 0, 0, 32767, 255);
        add_twist(0, 0, 500);
        add_twist(1000, -1000, 0);
        add_twist(1000, 1000, 7);
        add_twist(0, 0, 0);
        drain();
        set_geometry(32767, 32767, 32767, 0, 0);
        add_twist(0, 0, 16'sh7fff);
        add_twist(1, 0, 1);
        add_twist(16'sh7fff, 16'sh7fff, 16'sh8000);
        calm = 1'b1;
        random_burst(150);
        drain();
        calm = 1'b0;
        set_geometry(819, 819, 205, 2560, 4);
        random_burst(300);
        drain();
        set_geometry($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                     $urandom_range(32767), $urandom_range(255));
        random_burst(250);
        hold_send = 1'b1;
        while (cmd_q.size() != 0 || in_valid) @(posedge clk);
        hold_send = 1'b0;
        random_burst(230);
        drain();
        if (mismatches == 0)
            $display("swerve_wheel_kinematics_top verification clean");
        else
            $display("swerve_wheel_kinematics_top verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("swerve_wheel_kinematics_top verification failed");
        $finish;
    end
endmodule
